// ----- hdl/kwbq_pkg.sv -----
// Shared types and constants for the K-weighting biquad cascade.
package kwbq_pkg;

   localparam int COEF_BITS      = 32;
   localparam int NUM_COEFS      = 7;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_A2 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HP_A1    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HP_A2    = 3'd6;

   localparam logic [2:0] ACC_HOLD = 3'd0;
   localparam logic [2:0] ACC_BIAS = 3'd1;
   localparam logic [2:0] ACC_ADD  = 3'd2;
   localparam logic [2:0] ACC_SUB  = 3'd3;
   localparam logic [2:0] ACC_HP   = 3'd4;

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef coef_type coef_array_type [NUM_COEFS];

   typedef struct packed {
      logic                      load;
      logic                      mul_en;
      logic [CSR_INDEX_BITS-1:0] mul_sel;
      logic [2:0]                acc_op;
      logic                      shelf_done;
      logic                      hp_done;
   } kwbq_cmd_type;

   typedef struct packed {
      logic out_stall;
   } kwbq_status_type;

endpackage

// ----- hdl/kwbq_req_if.sv -----
// Sample input channel: valid/ready handshake with a signed sample.
interface kwbq_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- hdl/kwbq_rsp_if.sv -----
// Result channel: valid/ready handshake with the weighted sample and clip flag.
interface kwbq_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] weighted;
   logic                          clipped;

   modport source (output valid, output weighted, output clipped, input ready);
   modport sink   (input valid, input weighted, input clipped, output ready);
endinterface

// ----- hdl/kwbq_regs.sv -----
// Coefficient register file written through the CSR port.
module kwbq_regs import kwbq_pkg::*; #(
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]      csr_wdata,
   output coef_array_type            coef
);

   localparam coef_type ONE_VAL = coef_type'(1) <<< COEF_FRAC_BITS;

   coef_array_type coef_ff;
   coef_array_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we && (csr_index <= REG_HP_A2)) begin
         coef_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= (i == int'(REG_SHELF_B0)) ? ONE_VAL : coef_type'(0);
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ----- hdl/kwbq_datapath.sv -----
// Shared multiplier, accumulator, rounding/saturation, history and result register.
module kwbq_datapath import kwbq_pkg::*; #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kwbq_cmd_type                  cmd,
   input  coef_array_type                coef,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          rsp_ready,
   output kwbq_status_type               status,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_weighted,
   output logic                          rsp_clipped
);

   localparam int S      = SAMPLE_BITS;
   localparam int F      = COEF_FRAC_BITS;
   localparam int PROD_W = COEF_BITS + S;
   localparam int ACC_W  = COEF_BITS + S + 3;
   localparam int QW     = ACC_W - F;
   localparam int DW     = S + 3;

   localparam logic signed [ACC_W-1:0] BIAS_VAL = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
   localparam logic signed [S-1:0]     MAX_VAL  = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0]     MIN_VAL  = {1'b1, {(S-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [S-1:0]      u_ff, ys_ff;
   logic                     sat_ff;
   logic signed [S-1:0]      sh_u_ff [2];
   logic signed [S-1:0]      sh_y_ff [2];
   logic signed [S-1:0]      hp_u_ff [2];
   logic signed [S-1:0]      hp_y_ff [2];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [S-1:0]      weighted_ff;
   logic                     clipped_ff;

   logic signed [S-1:0]      opd;
   coef_type                 coef_sel;
   logic [QW-1:0]            q;
   logic                     fin_sat;
   logic signed [S-1:0]      fin_val;
   logic signed [DW-1:0]     hp_d;

   always_comb begin
      coef_sel = coef[cmd.mul_sel];
      unique case (cmd.mul_sel)
         REG_SHELF_B0: opd = req_sample;
         REG_SHELF_B1: opd = sh_u_ff[0];
         REG_SHELF_B2: opd = sh_u_ff[1];
         REG_SHELF_A1: opd = sh_y_ff[0];
         REG_SHELF_A2: opd = sh_y_ff[1];
         REG_HP_A1:    opd = hp_y_ff[0];
         REG_HP_A2:    opd = hp_y_ff[1];
         default:      opd = '0;
      endcase
      prod_in = PROD_W'(coef_sel) * PROD_W'(opd);
   end

   // round half up is folded in as the accumulator's starting bias
   always_comb begin
      q       = acc_ff[ACC_W-1:F];
      fin_sat = !((&q[QW-1:S-1]) || !(|q[QW-1:S-1]));
      if (fin_sat) begin
         fin_val = q[QW-1] ? MIN_VAL : MAX_VAL;
      end else begin
         fin_val = q[S-1:0];
      end
      hp_d = DW'(fin_val) - (DW'(hp_u_ff[0]) <<< 1) + DW'(hp_u_ff[1]);
   end

   always_comb begin
      unique case (cmd.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_BIAS: acc_in = BIAS_VAL;
         ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_SUB:  acc_in = acc_ff - ACC_W'(prod_ff);
         ACC_HP:   acc_in = (ACC_W'(hp_d) <<< F) | BIAS_VAL;
         default:  acc_in = acc_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.hp_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.load) begin
         u_ff <= req_sample;
      end
      if (cmd.shelf_done) begin
         ys_ff  <= fin_val;
         sat_ff <= fin_sat;
      end
      if (cmd.hp_done) begin
         weighted_ff <= fin_val;
         clipped_ff  <= sat_ff | fin_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            sh_u_ff[i] <= '0;
            sh_y_ff[i] <= '0;
            hp_u_ff[i] <= '0;
            hp_y_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.hp_done) begin
            sh_u_ff[1] <= sh_u_ff[0];
            sh_u_ff[0] <= u_ff;
            sh_y_ff[1] <= sh_y_ff[0];
            sh_y_ff[0] <= ys_ff;
            hp_u_ff[1] <= hp_u_ff[0];
            hp_u_ff[0] <= ys_ff;
            hp_y_ff[1] <= hp_y_ff[0];
            hp_y_ff[0] <= fin_val;
         end
      end
   end

   assign status.out_stall = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weighted     = weighted_ff;
   assign rsp_clipped      = clipped_ff;

endmodule

// ----- hdl/kwbq_ctrl.sv -----
// Sequencer that steps the shared multiplier through both biquad stages.
module kwbq_ctrl import kwbq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  kwbq_status_type status,
   output kwbq_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [3:0] STEP_SHELF_B1   = 4'd1;
   localparam logic [3:0] STEP_SHELF_B2   = 4'd2;
   localparam logic [3:0] STEP_SHELF_A1   = 4'd3;
   localparam logic [3:0] STEP_SHELF_A2   = 4'd4;
   localparam logic [3:0] STEP_SHELF_SUM  = 4'd5;
   localparam logic [3:0] STEP_SHELF_DONE = 4'd6;
   localparam logic [3:0] STEP_HP_A2      = 4'd7;
   localparam logic [3:0] STEP_HP_SUM     = 4'd8;
   localparam logic [3:0] STEP_HP_DONE    = 4'd9;

   logic       state_ff, state_in;
   logic [3:0] step_ff, step_in;

   always_comb begin
      cmd        = '0;
      cmd.acc_op = ACC_HOLD;
      state_in   = state_ff;
      step_in    = step_ff;
      req_ready  = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = REG_SHELF_B0;
               cmd.acc_op  = ACC_BIAS;
               state_in    = ST_RUN;
               step_in     = STEP_SHELF_B1;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               STEP_SHELF_B1: begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = REG_SHELF_B1;
                  cmd.acc_op  = ACC_ADD;
               end
               STEP_SHELF_B2: begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = REG_SHELF_B2;
                  cmd.acc_op  = ACC_ADD;
               end
               STEP_SHELF_A1: begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = REG_SHELF_A1;
                  cmd.acc_op  = ACC_ADD;
               end
               STEP_SHELF_A2: begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = REG_SHELF_A2;
                  cmd.acc_op  = ACC_SUB;
               end
               STEP_SHELF_SUM: begin
                  cmd.acc_op = ACC_SUB;
               end
               STEP_SHELF_DONE: begin
                  cmd.shelf_done = 1'b1;
                  cmd.acc_op     = ACC_HP;
                  cmd.mul_en     = 1'b1;
                  cmd.mul_sel    = REG_HP_A1;
               end
               STEP_HP_A2: begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = REG_HP_A2;
                  cmd.acc_op  = ACC_SUB;
               end
               STEP_HP_SUM: begin
                  cmd.acc_op = ACC_SUB;
               end
               STEP_HP_DONE: begin
                  if (status.out_stall) begin
                     step_in = step_ff;
                  end else begin
                     cmd.hp_done = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- hdl/k_weighting_biquad_cascade.sv -----
// K-weighting pre-filter: a high-shelf biquad followed by a high-pass
// biquad, both direct form I, on signed samples with Q3.28 coefficients.
// A new sample is taken no earlier than the cycle after the result of the
// last one is written, once both stages are done, since a single 32 x
// SAMPLE_BITS multiplier computes all seven coefficient products in turn.
// A finished result waiting on the rsp side holds the block only at the
// point where the next result would be written. Sums are exact, rounded
// half up and saturated per stage; clipped reports saturation in either
// stage. Coefficients must be written through the csr port only while no
// sample is in flight, which the block does not enforce; indexes past the
// last register are ignored.
module k_weighting_biquad_cascade import kwbq_pkg::*; #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   kwbq_req_if.sink                  req_if,
   kwbq_rsp_if.source                rsp_if,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]      csr_wdata
);

   coef_array_type  coef;
   kwbq_cmd_type    ctrl_cmd;
   kwbq_status_type dp_status;

   kwbq_regs #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   kwbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   kwbq_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (ctrl_cmd),
      .coef         (coef),
      .req_sample   (req_if.sample),
      .rsp_ready    (rsp_if.ready),
      .status       (dp_status),
      .rsp_valid    (rsp_if.valid),
      .rsp_weighted (rsp_if.weighted),
      .rsp_clipped  (rsp_if.clipped)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("sample accepted while a transaction is in flight");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(ctrl_cmd.hp_done))
      else $error("result valid without a finished transaction");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.hp_done |-> !(rsp_if.valid && !rsp_if.ready))
      else $error("pending result overwritten");

   a_single_finish: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.hp_done |=> !ctrl_cmd.hp_done && !ctrl_cmd.shelf_done)
      else $error("finish step repeated");
`endif

endmodule

// ----- tb/sv/tb_k_weighting_biquad_cascade.sv -----
// Testbench for the K-weighting biquad cascade: directed and random samples checked against a predictor.
`timescale 1ns / 1ps
module tb_k_weighting_biquad_cascade;
   import kwbq_pkg::*;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 28;
   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int PRINT_LIMIT    = 200;

   typedef logic signed [95:0]            wide_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef struct packed {
      sample_type weighted;
      logic       clipped;
   } result_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = CSR_INDEX_BITS'(NUM_COEFS);
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam coef_type   COEF_MAX   = 32'sh7fffffff;
   localparam coef_type   COEF_MIN   = 32'sh80000000;
   localparam coef_type   COEF_ONE   = 32'sh10000000;
   localparam coef_type   COEF_HALF  = 32'sh08000000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COEF_BITS-1:0]      csr_wdata;

   kwbq_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   kwbq_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();

   k_weighting_biquad_cascade #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   coef_array_type coef_shadow;
   sample_type     shelf_in [2];
   sample_type     shelf_out [2];
   sample_type     hp_in [2];
   sample_type     hp_out [2];
   sample_type     samples_pending [$];
   result_type     weighted_due [$];
   int unsigned    errors = 0;
   int unsigned    cycles = 0;
   int unsigned    req_gap = 0;
   int unsigned    rsp_gap = 0;
   bit             req_taken = 1'b0;
   bit             steady = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (errors < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycles, msg);
      end
      errors++;
   endtask

   // Round half up, drop the fraction, saturate to the sample width.
   function automatic sample_type round_saturate(input wide_type acc, inout logic clipped);
      wide_type r;
      r = (acc + (wide_type'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (r > wide_type'(SAMPLE_MAX)) begin
         clipped = 1'b1;
         return SAMPLE_MAX;
      end
      if (r < wide_type'(SAMPLE_MIN)) begin
         clipped = 1'b1;
         return SAMPLE_MIN;
      end
      return sample_type'(r);
   endfunction

   function automatic result_type kweight_step(input sample_type x);
      wide_type   acc;
      sample_type ys;
      sample_type yh;
      logic       clipped;
      clipped = 1'b0;
      acc = wide_type'(coef_shadow[REG_SHELF_B0]) * wide_type'(x)
          + wide_type'(coef_shadow[REG_SHELF_B1]) * wide_type'(shelf_in[0])
          + wide_type'(coef_shadow[REG_SHELF_B2]) * wide_type'(shelf_in[1])
          - wide_type'(coef_shadow[REG_SHELF_A1]) * wide_type'(shelf_out[0])
          - wide_type'(coef_shadow[REG_SHELF_A2]) * wide_type'(shelf_out[1]);
      ys = round_saturate(acc, clipped);
      shelf_in[1]  = shelf_in[0];
      shelf_in[0]  = x;
      shelf_out[1] = shelf_out[0];
      shelf_out[0] = ys;
      acc = ((wide_type'(ys) - 2 * wide_type'(hp_in[0]) + wide_type'(hp_in[1]))
             <<< COEF_FRAC_BITS)
          - wide_type'(coef_shadow[REG_HP_A1]) * wide_type'(hp_out[0])
          - wide_type'(coef_shadow[REG_HP_A2]) * wide_type'(hp_out[1]);
      yh = round_saturate(acc, clipped);
      hp_in[1]  = hp_in[0];
      hp_in[0]  = ys;
      hp_out[1] = hp_out[0];
      hp_out[0] = yh;
      return '{weighted: yh, clipped: clipped};
   endfunction

   function automatic sample_type random_sample(input sample_type prev);
      case ($urandom_range(0, 9))
         0, 1, 2: return sample_type'($urandom());
         3, 4, 5: return sample_type'(int'($urandom_range(0, 4096)) - 2048);
         6:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         7, 8:    return prev;
         default: return sample_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   function automatic coef_type random_coef();
      case ($urandom_range(0, 5))
         0, 1:    return coef_type'($urandom());
         2, 3:    return coef_type'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
         4:       return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
         default: return $urandom_range(0, 1) ? COEF_ONE : coef_type'(0);
      endcase
   endfunction

   task automatic queue_random(input int n);
      sample_type s;
      s = '0;
      repeat (n) begin
         s = random_sample(s);
         samples_pending.push_back(s);
      end
   endtask

   task automatic write_coef(input logic [CSR_INDEX_BITS-1:0] idx, input coef_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx < NUM_COEFS) begin
         coef_shadow[idx] = value;
      end
   endtask

   // Every register, then one write to the unused index, which must be ignored.
   task automatic load_coefs(input coef_array_type c);
      for (int i = 0; i < NUM_COEFS; i++) begin
         write_coef(CSR_INDEX_BITS'(i), c[i]);
      end
      write_coef(REG_UNUSED, coef_type'($urandom()));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (samples_pending.size() != 0 || req_if.valid || weighted_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Monitor: check results first, then predict for the transaction accepted this edge.
   always @(posedge clock) begin
      result_type due;
      req_taken = req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (weighted_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result weighted=%0d", rsp_if.weighted));
            end else begin
               due = weighted_due.pop_front();
               if (rsp_if.weighted !== due.weighted) begin
                  report_mismatch($sformatf("weighted %0d, expected %0d",
                                            rsp_if.weighted, due.weighted));
               end
               if (rsp_if.clipped !== due.clipped) begin
                  report_mismatch($sformatf("clipped %b, expected %b",
                                            rsp_if.clipped, due.clipped));
               end
            end
         end
         if (req_taken) begin
            weighted_due.push_back(kweight_step(req_if.sample));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (samples_pending.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (!steady && $urandom_range(0, 15) == 0) begin
            req_gap = $urandom_range(0, 18);
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid  <= 1'b1;
            req_if.sample <= samples_pending.pop_front();
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 23) == 0) begin
         rsp_gap = $urandom_range(0, 18);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      coef_array_type kweight_48k;
      coef_array_type c;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      rsp_if.ready  = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      coef_shadow   = '{COEF_ONE, 0, 0, 0, 0, 0, 0};
      shelf_in      = '{0, 0};
      shelf_out     = '{0, 0};
      hp_in         = '{0, 0};
      hp_out        = '{0, 0};
      // roughly the 48 kHz pre-filter
      kweight_48k   = '{32'sd412081942, -32'sd722546694, 32'sd321691120,
                        -32'sd453832899, 32'sd196623811, -32'sd534199296, 32'sd265770496};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients: pass-through shelf, bare second difference
      samples_pending.push_back(0);
      samples_pending.push_back(SAMPLE_MAX);
      samples_pending.push_back(SAMPLE_MIN);
      samples_pending.push_back(SAMPLE_MAX);
      samples_pending.push_back(SAMPLE_MIN);
      samples_pending.push_back(1);
      samples_pending.push_back(-1);
      samples_pending.push_back(0);
      samples_pending.push_back(0);
      drain();

      // shelf overflow
      load_coefs('{COEF_MAX, 0, 0, 0, 0, 0, 0});
      samples_pending.push_back(sample_type'(1 << 20));
      samples_pending.push_back(sample_type'(-(1 << 20)));
      samples_pending.push_back(sample_type'((1 << 20) - 1));
      samples_pending.push_back(sample_type'(-(1 << 20) - 1));
      samples_pending.push_back(100);
      samples_pending.push_back(0);
      drain();

      // half-way rounding
      load_coefs('{COEF_HALF, 0, 0, 0, 0, 0, 0});
      samples_pending.push_back(1);
      samples_pending.push_back(-1);
      samples_pending.push_back(3);
      samples_pending.push_back(-3);
      samples_pending.push_back(5);
      drain();

      load_coefs(kweight_48k);
      samples_pending.push_back(SAMPLE_MAX);
      samples_pending.push_back(0);
      samples_pending.push_back(0);
      samples_pending.push_back(0);
      queue_random(400);
      drain();

      load_coefs('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX});
      queue_random(80);
      drain();

      load_coefs('{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN});
      queue_random(80);
      drain();

      repeat (4) begin
         foreach (c[i]) c[i] = random_coef();
         load_coefs(c);
         queue_random(250);
         drain();
      end

      load_coefs(kweight_48k);
      steady = 1'b1;
      queue_random(300);
      drain();

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
